FILE: hw/rtl/cs_pkg.sv
package cs_pkg;

    localparam int ELEM_W   = 16;
    localparam int COS_W    = 16;
    localparam int MAX_DIMS = 1024;
    localparam int DIM_W    = $clog2(MAX_DIMS);
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int DOT_W    = PROD_W + DIM_W;
    localparam int SQ_W     = PROD_W - 1 + DIM_W;
    localparam int SQP_W    = 2 * SQ_W;
    localparam int RHS_W    = 2 * DOT_W;
    localparam int FRAC_SH  = 2 * (COS_W - 1);
    localparam int ACC_W    = RHS_W + FRAC_SH;
    localparam int K_W      = COS_W;
    localparam int BIT_W    = $clog2(K_W);

    localparam logic [COS_W-1:0] COS_MAX = {1'b0, {(COS_W - 1){1'b1}}};

    typedef enum logic [2:0] {
        S_ACCUM,
        S_WAIT,
        S_CAPT,
        S_MULQD,
        S_MULMM,
        S_TLOAD,
        S_TMUL,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_STEP,
        OP_SAVE_P,
        OP_SAVE_R,
        OP_LOAD_TRIAL,
        OP_JUDGE,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic take;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic zero;
        logic last_bit;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/cs_if.sv
interface cs_in_if import cs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] query_element;
    logic signed [ELEM_W-1:0] doc_element;
    logic                     last_element;

    modport source (output valid, query_element, doc_element, last_element, input ready);
    modport sink   (input valid, query_element, doc_element, last_element, output ready);
endinterface

interface cs_out_if import cs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [COS_W-1:0] cosine;
    logic                    zero_dot;

    modport source (output valid, cosine, zero_dot, input ready);
    modport sink   (input valid, cosine, zero_dot, output ready);
endinterface

FILE: hw/rtl/cosine_similarity.sv
// Streaming cosine similarity of a query vector and a document vector.
// The input channel carries one component of each vector per transfer, both
// signed Q4.12, with last_element marking the final pair. Components are
// taken at one per cycle while the vector streams in, and the dot product and
// both sums of squares accumulate with saturation at their register bounds.
// After the last transfer the block stops accepting input and works out the
// cosine in signed Q1.15 with a shift-and-add multiplier that handles one
// multiplier bit per cycle: the product of the sums of squares, the square of
// the dot product, then sixteen trial steps that settle the result one bit at
// a time. The result is then registered on the output channel; when the
// dot product is zero the multiplications and trial steps are skipped,
// zero_dot is set and cosine is zero. Input is accepted again from the cycle
// after the result is registered, while that result waits to be taken.
// If the receiver stalls, the result holds and a second result waits inside
// the block until the first has been taken.
// Reset clears the dot product and both sums of squares and empties the
// output register.
module cosine_similarity import cs_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    cs_in_if.sink   i_in,
    cs_out_if.source o_out
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_ready;
    logic    w_valid;
    logic signed [COS_W-1:0] w_cosine;
    logic    w_zero_dot;

    cs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_last   (i_in.last_element),
        .o_ready  (w_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    cs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_query_element (i_in.query_element),
        .i_doc_element   (i_in.doc_element),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_valid         (w_valid),
        .o_cosine        (w_cosine),
        .o_zero_dot      (w_zero_dot),
        .i_ready         (o_out.ready)
    );

    assign i_in.ready     = w_ready;
    assign o_out.valid    = w_valid;
    assign o_out.cosine   = w_cosine;
    assign o_out.zero_dot = w_zero_dot;

endmodule

FILE: hw/rtl/cs_ctrl.sv
module cs_ctrl import cs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        o_cmd    = '{op: OP_NONE, take: 1'b0};
        unique case (r_state)
            S_ACCUM: begin
                o_ready    = i_rst_n;
                o_cmd.take = i_valid && i_rst_n;
                if (i_valid && i_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_CAPT;
            end
            S_CAPT: begin
                o_cmd.op = OP_CAPTURE;
                n_state  = S_MULQD;
            end
            S_MULQD: begin
                priority if (i_status.zero) begin
                    n_state = S_DONE;
                end else if (i_status.mul_done) begin
                    o_cmd.op = OP_SAVE_P;
                    n_state  = S_MULMM;
                end else begin
                    o_cmd.op = OP_STEP;
                end
            end
            S_MULMM: begin
                if (i_status.mul_done) begin
                    o_cmd.op = OP_SAVE_R;
                    n_state  = S_TLOAD;
                end else begin
                    o_cmd.op = OP_STEP;
                end
            end
            S_TLOAD: begin
                o_cmd.op = OP_LOAD_TRIAL;
                n_state  = S_TMUL;
            end
            S_TMUL: begin
                if (i_status.mul_done) begin
                    o_cmd.op = OP_JUDGE;
                    n_state  = i_status.last_bit ? S_DONE : S_TLOAD;
                end else begin
                    o_cmd.op = OP_STEP;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cs_dp.sv
module cs_dp import cs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [ELEM_W-1:0] i_query_element,
    input  logic signed [ELEM_W-1:0] i_doc_element,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output logic                     o_valid,
    output logic signed [COS_W-1:0]  o_cosine,
    output logic                     o_zero_dot,
    input  logic                     i_ready
);

    logic signed [PROD_W-1:0] w_qq;
    logic signed [PROD_W-1:0] w_dd;

    logic [PROD_W-1:0]   r_p_dot;
    logic [PROD_W-2:0]   r_p_qq;
    logic [PROD_W-2:0]   r_p_dd;
    logic                r_p_vld;

    logic [DOT_W-1:0]    r_dot;
    logic [SQ_W-1:0]     r_qsum;
    logic [SQ_W-1:0]     r_dsum;
    logic [DOT_W:0]      w_dot_raw;
    logic [SQ_W:0]       w_q_raw;
    logic [SQ_W:0]       w_d_raw;
    logic [DOT_W-1:0]    n_dot;
    logic [SQ_W-1:0]     n_qsum;
    logic [SQ_W-1:0]     n_dsum;

    logic [DOT_W-1:0]    r_mag;
    logic                r_neg;
    logic                r_zero;
    logic [SQP_W-1:0]    r_p;
    logic [RHS_W-1:0]    r_rhs;

    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    r_mcand;
    logic [DOT_W-1:0]    r_mplier;

    logic [K_W-1:0]      r_k;
    logic [BIT_W-1:0]    r_bit;
    logic [K_W-1:0]      w_cand;
    logic [2*K_W-1:0]    w_cand_sq;
    logic                w_fits;

    logic                r_o_valid;
    logic [COS_W-1:0]    r_cos;
    logic                r_zd;
    logic [COS_W-1:0]    w_cos;

    assign w_qq = i_query_element * i_query_element;
    assign w_dd = i_doc_element * i_doc_element;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_p_dot <= i_query_element * i_doc_element;
            r_p_qq  <= w_qq[PROD_W-2:0];
            r_p_dd  <= w_dd[PROD_W-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.take;
        end
    end

    assign w_dot_raw = {r_dot[DOT_W-1], r_dot}
                     + {{(DOT_W + 1 - PROD_W){r_p_dot[PROD_W-1]}}, r_p_dot};
    assign w_q_raw   = {1'b0, r_qsum} + (SQ_W + 1)'(r_p_qq);
    assign w_d_raw   = {1'b0, r_dsum} + (SQ_W + 1)'(r_p_dd);

    always_comb begin
        if (w_dot_raw[DOT_W] != w_dot_raw[DOT_W-1]) begin
            n_dot = w_dot_raw[DOT_W] ? {1'b1, {(DOT_W - 1){1'b0}}}
                                     : {1'b0, {(DOT_W - 1){1'b1}}};
        end else begin
            n_dot = w_dot_raw[DOT_W-1:0];
        end
        n_qsum = w_q_raw[SQ_W] ? {SQ_W{1'b1}} : w_q_raw[SQ_W-1:0];
        n_dsum = w_d_raw[SQ_W] ? {SQ_W{1'b1}} : w_d_raw[SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == OP_CAPTURE) begin
            r_dot  <= '0;
            r_qsum <= '0;
            r_dsum <= '0;
        end else if (r_p_vld) begin
            r_dot  <= n_dot;
            r_qsum <= n_qsum;
            r_dsum <= n_dsum;
        end
    end

    assign w_cand    = r_k | (K_W'(1) << r_bit);
    assign w_cand_sq = w_cand * w_cand;
    assign w_fits    = !r_k[K_W-1] && (r_acc <= {r_rhs, {FRAC_SH{1'b0}}});

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_neg    <= r_dot[DOT_W-1];
                r_zero   <= (r_dot == '0);
                r_mag    <= r_dot[DOT_W-1] ? (~r_dot + DOT_W'(1)) : r_dot;
                r_acc    <= '0;
                r_mcand  <= ACC_W'(r_qsum);
                r_mplier <= DOT_W'(r_dsum);
            end
            OP_STEP: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
            end
            OP_SAVE_P: begin
                r_p      <= r_acc[SQP_W-1:0];
                r_acc    <= '0;
                r_mcand  <= ACC_W'(r_mag);
                r_mplier <= r_mag;
            end
            OP_SAVE_R: begin
                r_rhs <= r_acc[RHS_W-1:0];
                r_k   <= '0;
                r_bit <= BIT_W'(K_W - 1);
            end
            OP_LOAD_TRIAL: begin
                r_acc    <= '0;
                r_mcand  <= ACC_W'(r_p);
                r_mplier <= DOT_W'(w_cand_sq);
            end
            OP_JUDGE: begin
                if (w_fits) begin
                    r_k <= w_cand;
                end
                r_bit <= r_bit - BIT_W'(1);
            end
            OP_NONE, OP_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        priority if (r_zero) begin
            w_cos = '0;
        end else if (r_neg) begin
            w_cos = ~r_k + K_W'(1);
        end else if (r_k[K_W-1]) begin
            w_cos = COS_MAX;
        end else begin
            w_cos = r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.op == OP_RESULT) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RESULT) begin
            r_cos <= w_cos;
            r_zd  <= r_zero;
        end
    end

    assign o_status.mul_done = (r_mplier == '0);
    assign o_status.zero     = r_zero;
    assign o_status.last_bit = (r_bit == '0);
    assign o_status.out_free = !r_o_valid || i_ready;

    assign o_valid    = r_o_valid;
    assign o_cosine   = r_cos;
    assign o_zero_dot = r_zd;

endmodule

FILE: hw/rtl/cs_check.sv
module cs_check import cs_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_last,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [COS_W-1:0] i_out_cosine,
    input logic             i_out_zero_dot
);

    // A result stays offered until its transfer completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transfer");

    a_zero_cos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_zero_dot |-> i_out_cosine == '0)
        else $error("zero dot product with nonzero cosine");

    // The block stops taking input once the final component has been taken.
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input accepted straight after the last component");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

endmodule

bind cosine_similarity cs_check u_cs_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_last      (i_in.last_element),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_cosine   (o_out.cosine),
    .i_out_zero_dot (o_out.zero_dot)
);
